@@ hw/rtl/tube_waveshaper_feedback_defines.svh @@
// Assertion macros for the tube waveshaper block.
// Included by the top level; no other dependencies.
`ifndef TUBE_WAVESHAPER_FEEDBACK_DEFINES_SVH
`define TUBE_WAVESHAPER_FEEDBACK_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define TW_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define TW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TW_ASSERT(lbl, clk, rstn, prop, msg)
`define TW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ hw/rtl/tw_pkg.sv @@
// Shared types, constants and helpers for the tube waveshaper block.
// No dependencies.
`timescale 1ns / 1ps

package tw_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int CHANNELS    = 2;

	localparam int TAB_AW    = $clog2(TABLE_DEPTH);
	localparam int DEPTH_W   = $clog2(TABLE_DEPTH) + 1;
	localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int FRAC_STEP = 21;
	localparam int POS_W     = 25 + DEPTH_W + 1;
	localparam int ADDR_X_W  = 17;

	localparam logic signed [23:0] SMAX = 24'sh7FFFFF;
	localparam logic signed [23:0] SMIN = 24'sh800000;

	// command codes of an input request
	localparam logic CMD_WRITE_TABLE = 1'b0;
	localparam logic CMD_SAMPLE      = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_DRIVE_GAIN     = 2'd0;
	localparam logic [1:0] REG_SUPPLY_LEVEL   = 2'd1;
	localparam logic [1:0] REG_FEEDBACK_RATIO = 2'd2;

	typedef struct packed {
		logic              command;
		logic              channel;
		logic [9:0]        table_address;
		logic signed [23:0] table_value;
		logic signed [23:0] sample_in;
	} in_req_t;

	typedef struct packed {
		logic              channel_out;
		logic signed [23:0] sample_out;
	} out_req_t;

	typedef struct packed {
		logic [23:0]        drive_gain;
		logic signed [23:0] supply_level;
		logic signed [23:0] feedback_ratio;
	} cfg_t;

	// datapath step strobes from the controller
	typedef struct packed {
		logic wr_table;
		logic load;
		logic mul;
		logic sum;
		logic pos;
		logic rd_a;
		logic rd_b;
		logic interp;
		logic yout;
		logic fbmul;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'(SMAX);
		lo = 64'(SMIN);
		if (v > hi) begin
			return SMAX;
		end else if (v < lo) begin
			return SMIN;
		end
		return v[23:0];
	endfunction

endpackage

@@ hw/rtl/tube_waveshaper_feedback.sv @@
// Top level of the tube drive stage with per-channel feedback.
// Depends on tw_pkg, tw_ctrl, tw_dp and tube_waveshaper_feedback_defines.svh.
//
//   port group   direction  handshake             payload
//   in_*         in         in_valid / in_stall   tw_pkg::in_req_t
//   out_*        out        out_valid / out_stall tw_pkg::out_req_t
//   APB          in         psel/penable/pready   paddr, pwdata, prdata
//
// A table write request leaves the sequencer idle; the block is ready again the next cycle.
// A sample request holds off the next acceptance while it steps through the
// chain of registered multipliers plus two reads through the single table read port.
// A result waits in the output register while out_stall is high; the feedback
// update and the next acceptance hold until that register can take the result.
// Reset clears the controller, the feedback state, the output valid and the
// registers (drive gain 1.0); curve table contents are undefined until written.
`timescale 1ns / 1ps
`include "tube_waveshaper_feedback_defines.svh"

module tube_waveshaper_feedback (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  tw_pkg::in_req_t    in_req,
	output logic               out_valid,
	input  logic               out_stall,
	output tw_pkg::out_req_t   out_req,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	tw_pkg::cfg_t    cfg_q;
	tw_pkg::cmd_t    cmd;
	tw_pkg::status_t status;
	logic            cfg_wr;
	logic [1:0]      reg_idx;

	// APB register file: always ready, write on the access phase
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drive_gain     <= 24'd65536;
			cfg_q.supply_level   <= '0;
			cfg_q.feedback_ratio <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				tw_pkg::REG_DRIVE_GAIN:     cfg_q.drive_gain     <= pwdata[23:0];
				tw_pkg::REG_SUPPLY_LEVEL:   cfg_q.supply_level   <= pwdata[23:0];
				tw_pkg::REG_FEEDBACK_RATIO: cfg_q.feedback_ratio <= pwdata[23:0];
				default: begin
					// drop writes beyond the register list
				end
			endcase
		end
	end

	// read back, zero-extended to the bus width
	always_comb begin
		unique case (reg_idx)
			tw_pkg::REG_DRIVE_GAIN:     prdata = 32'(cfg_q.drive_gain);
			tw_pkg::REG_SUPPLY_LEVEL:   prdata = 32'(unsigned'(cfg_q.supply_level));
			tw_pkg::REG_FEEDBACK_RATIO: prdata = 32'(unsigned'(cfg_q.feedback_ratio));
			default:                    prdata = '0;
		endcase
	end

	// sequencer: accept requests, advance one datapath step per cycle, holding the last step while the output is full
	tw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_command (in_req.command),
		.in_stall   (in_stall),
		.status     (status),
		.cmd        (cmd)
	);

	// datapath: table, interpolation, feedback state and output register
	tw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg       (cfg_q),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_req   (out_req)
	);

	// a sample request must lock out the input on the next cycle
	`TW_ASSERT(a_sample_locks_input, clk, arst_n, (in_valid && !in_stall && (in_req.command == tw_pkg::CMD_SAMPLE)) |=> in_stall, "sample request did not hold off input")
	// a finished sample shows up at the output
	`TW_ASSERT(a_fin_gives_result, clk, arst_n, cmd.fin |=> out_valid, "finished sample not presented")
	// never overwrite a result that is still waiting
	`TW_ASSERT(a_fin_needs_room, clk, arst_n, cmd.fin |-> status.out_free, "result overwritten while stalled")
	// at most one datapath step at a time
	`TW_ASSERT_ALWAYS(a_one_step, clk, $onehot0({cmd.mul, cmd.sum, cmd.pos, cmd.rd_a, cmd.rd_b, cmd.interp, cmd.yout, cmd.fbmul, cmd.fin}), "overlapping datapath steps")

endmodule

@@ hw/rtl/tw_ctrl.sv @@
// Sequencer for the tube waveshaper: steps one sample through the datapath.
// Depends on tw_pkg.
`timescale 1ns / 1ps

module tw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_command,
	output logic              in_stall,
	input  tw_pkg::status_t   status,
	output tw_pkg::cmd_t      cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_MUL    = 4'd1;
	localparam logic [3:0] ST_SUM    = 4'd2;
	localparam logic [3:0] ST_POS    = 4'd3;
	localparam logic [3:0] ST_RDA    = 4'd4;
	localparam logic [3:0] ST_RDB    = 4'd5;
	localparam logic [3:0] ST_INTERP = 4'd6;
	localparam logic [3:0] ST_YOUT   = 4'd7;
	localparam logic [3:0] ST_FBMUL  = 4'd8;
	localparam logic [3:0] ST_FIN    = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		cmd.wr_table = accept && (in_command == tw_pkg::CMD_WRITE_TABLE);
		cmd.load     = accept && (in_command == tw_pkg::CMD_SAMPLE);
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load) state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_POS;
			end
			ST_POS: begin
				cmd.pos = 1'b1;
				state_d = ST_RDA;
			end
			ST_RDA: begin
				cmd.rd_a = 1'b1;
				state_d  = ST_RDB;
			end
			ST_RDB: begin
				cmd.rd_b = 1'b1;
				state_d  = ST_INTERP;
			end
			ST_INTERP: begin
				cmd.interp = 1'b1;
				state_d    = ST_YOUT;
			end
			ST_YOUT: begin
				cmd.yout = 1'b1;
				state_d  = ST_FBMUL;
			end
			ST_FBMUL: begin
				cmd.fbmul = 1'b1;
				state_d   = ST_FIN;
			end
			ST_FIN: begin
				if (status.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hw/rtl/tw_dp.sv @@
// Datapath of the tube waveshaper: gain, curve table, interpolation, feedback.
// Depends on tw_pkg; driven by tw_ctrl strobes.
`timescale 1ns / 1ps

module tw_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  tw_pkg::cmd_t       cmd,
	output tw_pkg::status_t    status,
	input  tw_pkg::cfg_t       cfg,
	input  tw_pkg::in_req_t    in_req,
	output logic               out_valid,
	input  logic               out_stall,
	output tw_pkg::out_req_t   out_req
);

	localparam logic signed [tw_pkg::POS_W-1:0] DEPTH_S = tw_pkg::POS_W'(tw_pkg::TABLE_DEPTH);
	localparam logic signed [tw_pkg::POS_W-1:0] POS_TOP =
		tw_pkg::POS_W'(longint'(tw_pkg::TABLE_DEPTH - 1) << tw_pkg::FRAC_STEP);
	localparam logic [tw_pkg::ADDR_X_W-1:0] DEPTH_X = tw_pkg::ADDR_X_W'(tw_pkg::TABLE_DEPTH);
	localparam logic signed [24:0] HALF_SPAN = 25'sh100000;

	logic signed [23:0] curve_mem [tw_pkg::TABLE_DEPTH];
	logic signed [23:0] rdata_q;
	logic signed [23:0] fb_q [tw_pkg::CHANNELS];

	logic                       ch_field_q;
	logic [tw_pkg::CH_W-1:0]    ch_q;
	logic signed [23:0]         s_q;
	logic signed [48:0]         gprod_q;
	logic signed [23:0]         x_q;
	logic [tw_pkg::TAB_AW-1:0]  addr_q;
	logic [tw_pkg::FRAC_STEP-1:0] w_q;
	logic                       clamp_q;
	logic signed [23:0]         a_q;
	logic signed [46:0]         iprod_q;
	logic signed [23:0]         y_q;
	logic signed [48:0]         fprod_q;
	logic                       out_valid_q;
	tw_pkg::out_req_t           out_q;

	logic [tw_pkg::ADDR_X_W-1:0]   wr_addr_x;
	logic                          rd_en;
	logic [tw_pkg::TAB_AW-1:0]     rd_addr;
	logic signed [63:0]            gsum;
	logic signed [24:0]            xo;
	logic signed [tw_pkg::POS_W-1:0] pos;
	logic                          pos_lo;
	logic                          pos_hi;
	logic signed [24:0]            tdiff;
	logic signed [47:0]            iacc;
	logic signed [25:0]            ishift;
	logic signed [24:0]            fdiff;
	logic [tw_pkg::CH_W-1:0]       ch_idx;

	assign ch_idx = (tw_pkg::CHANNELS > 1) ? tw_pkg::CH_W'(in_req.channel) : '0;

	// curve table: one write port, one registered read port
	assign wr_addr_x = tw_pkg::ADDR_X_W'(in_req.table_address);
	assign rd_en     = cmd.rd_a || cmd.rd_b;
	assign rd_addr   = cmd.rd_b ? (addr_q + 1'b1) : addr_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_table && (wr_addr_x < DEPTH_X)) begin
			curve_mem[wr_addr_x[tw_pkg::TAB_AW-1:0]] <= in_req.table_value;
		end
		if (rd_en) begin
			rdata_q <= curve_mem[rd_addr];
		end
	end

	// combinational step logic
	assign gsum   = 64'(gprod_q >>> 16) + 64'(fb_q[ch_q]);
	assign xo     = 25'(x_q) + HALF_SPAN;
	assign pos    = tw_pkg::POS_W'(xo) * DEPTH_S;
	assign pos_lo = pos[tw_pkg::POS_W-1];
	assign pos_hi = (pos >= POS_TOP);
	assign tdiff  = 25'(rdata_q) - 25'(a_q);
	assign iacc   = (48'(a_q) <<< tw_pkg::FRAC_STEP) + 48'(iprod_q);
	assign ishift = 26'(iacc >>> (tw_pkg::FRAC_STEP + 1));
	assign fdiff  = 25'(cfg.supply_level) - 25'(y_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s_q        <= in_req.sample_in;
			ch_field_q <= in_req.channel;
			ch_q       <= ch_idx;
		end
		if (cmd.mul) begin
			gprod_q <= 49'($signed({1'b0, cfg.drive_gain})) * 49'(s_q);
		end
		if (cmd.sum) begin
			x_q <= tw_pkg::sat24(gsum);
		end
		if (cmd.pos) begin
			clamp_q <= pos_lo || pos_hi;
			w_q     <= pos[tw_pkg::FRAC_STEP-1:0];
			priority if (pos_lo) begin
				addr_q <= '0;
			end else if (pos_hi) begin
				addr_q <= tw_pkg::TAB_AW'(tw_pkg::TABLE_DEPTH - 1);
			end else begin
				addr_q <= pos[tw_pkg::FRAC_STEP +: tw_pkg::TAB_AW];
			end
		end
		if (cmd.rd_b) begin
			a_q <= rdata_q;
		end
		if (cmd.interp) begin
			iprod_q <= 47'(tdiff) * 47'($signed({1'b0, w_q}));
		end
		if (cmd.yout) begin
			y_q <= clamp_q ? a_q : tw_pkg::sat24(64'(ishift));
		end
		if (cmd.fbmul) begin
			fprod_q <= 49'(fdiff) * 49'(cfg.feedback_ratio);
		end
		if (cmd.fin) begin
			out_q.channel_out <= ch_field_q;
			out_q.sample_out  <= y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tw_pkg::CHANNELS; i++) begin
				fb_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fin) begin
				fb_q[ch_q] <= tw_pkg::sat24(64'(fprod_q >>> 20));
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign out_req         = out_q;

endmodule
